[design/rope_pkg.sv]
// shared constants and types for the rotary position embedding rotator
package rope_pkg;

    localparam int MAX_HALF_DIM  = 64;
    localparam int MAX_POSITIONS = 1024;

    localparam int DATA_W  = 16;
    localparam int HALF_W  = 7;
    localparam int ELEM_W  = 7;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 2;
    localparam int POS_W   = 10;
    localparam int PIDX_W  = 6;
    localparam int CNT_W   = $clog2(2 * MAX_HALF_DIM);
    localparam int COL_W   = $clog2(MAX_HALF_DIM);
    localparam int ROW_W   = $clog2(MAX_POSITIONS);
    localparam int TBL_AW  = ROW_W + COL_W;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int FRAC_W  = 14;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 24;

    localparam logic OP_TABLE = 1'b0;
    localparam logic OP_ELEM  = 1'b1;

    localparam logic [CIDX_W-1:0] REG_HALF_DIM = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LAYOUT   = 2'd1;

    localparam logic LAYOUT_SPLIT       = 1'b0;
    localparam logic LAYOUT_INTERLEAVED = 1'b1;

    // pipeline tag of one element request
    typedef struct packed {
        logic             pair;
        logic [CNT_W-1:0] idx0;
        logic [CNT_W-1:0] idx1;
    } rope_tag_t;

endpackage

[design/rope_pair_mul.sv]
// rotation of one element pair: registered products, then sum, round and saturate
module rope_pair_mul (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  rope_pkg::rope_tag_t                tag_in,
    input  logic signed [rope_pkg::DATA_W-1:0] x0,
    input  logic signed [rope_pkg::DATA_W-1:0] x1,
    input  logic signed [rope_pkg::DATA_W-1:0] sin_v,
    input  logic signed [rope_pkg::DATA_W-1:0] cos_v,
    output rope_pkg::rope_tag_t                tag_out,
    output logic signed [rope_pkg::DATA_W-1:0] y0,
    output logic signed [rope_pkg::DATA_W-1:0] y1
);

    rope_pkg::rope_tag_t                 tag_reg;
    logic signed [rope_pkg::PROD_W-1:0]  x0c_reg;
    logic signed [rope_pkg::PROD_W-1:0]  x1s_reg;
    logic signed [rope_pkg::PROD_W-1:0]  x0s_reg;
    logic signed [rope_pkg::PROD_W-1:0]  x1c_reg;
    logic signed [rope_pkg::ACC_W-1:0]   acc0;
    logic signed [rope_pkg::ACC_W-1:0]   acc1;

    function automatic logic signed [rope_pkg::DATA_W-1:0] round_sat(
        input logic signed [rope_pkg::ACC_W-1:0] acc
    );
        logic signed [rope_pkg::ACC_W-1:0] t;
        logic signed [rope_pkg::ACC_W-1:0] q;
        logic signed [rope_pkg::ACC_W-1:0] max_v;
        logic signed [rope_pkg::ACC_W-1:0] min_v;
        max_v = rope_pkg::ACC_W'(2 ** (rope_pkg::DATA_W - 1) - 1);
        min_v = -max_v - rope_pkg::ACC_W'(1);
        // half toward +inf, then floor
        t = acc + rope_pkg::ACC_W'(2 ** (rope_pkg::FRAC_W - 1));
        q = t >>> rope_pkg::FRAC_W;
        if (q > max_v)
        begin
            return max_v[rope_pkg::DATA_W-1:0];
        end
        else if (q < min_v)
        begin
            return min_v[rope_pkg::DATA_W-1:0];
        end
        return q[rope_pkg::DATA_W-1:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else if (en)
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0c_reg <= x0 * cos_v;
            x1s_reg <= x1 * sin_v;
            x0s_reg <= x0 * sin_v;
            x1c_reg <= x1 * cos_v;
        end
    end

    assign acc0 = rope_pkg::ACC_W'(x0c_reg) - rope_pkg::ACC_W'(x1s_reg);
    assign acc1 = rope_pkg::ACC_W'(x0s_reg) + rope_pkg::ACC_W'(x1c_reg);

    assign tag_out = tag_reg;
    assign y0      = round_sat(acc0);
    assign y1      = round_sat(acc1);

endmodule

[design/rotary_position_embedding_rotate.sv]
// rotary position embedding rotator top level
// usage:
//   s_axis carries one request per cycle; tuser is the op (0 table write,
//   1 head vector element). table writes load {sin, cos} at (pos_id, pair_index)
//   and give no result. elements are counted; the first element of a pair is
//   held in an on-chip buffer, the second one triggers the rotation.
//   m_axis then gives two results, the first element of the pair with tlast
//   low, then the second with tlast high.
//   cfg_we / cfg_index / cfg_data write half_dim (index 0) and layout (index 1);
//   a write to either register restarts the element count. write only while idle.
// timing:
//   one request accepted per cycle while s_axis_tready is high. once the
//   second element is accepted, the table and buffer are read on acceptance,
//   then the products are registered, then round and saturate go into the
//   output register and the two results leave in turn. pairs arriving every
//   two elements stream at one result per cycle while m_axis_tready is high.
//   when m_axis stalls, the whole pipeline holds and s_axis_tready drops once
//   a pair waits at the output; requests without a result keep flowing.
// reset:
//   clears the count and the pipeline; half_dim becomes 64 and layout 0.
//   the sine/cosine table and the held-element buffer are not cleared and
//   must be written before use.
module rotary_position_embedding_rotate (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // pos_id, pair_index, sin_val, cos_val, x_val
    input  logic [rope_pkg::IN_W-1:0]     s_axis_tdata,
    // op
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // y_val, elem_index, zero pad
    output logic [rope_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          cfg_we,
    input  logic [rope_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rope_pkg::CFG_W-1:0]    cfg_data
);

    localparam int HW = rope_pkg::HALF_W;
    localparam int CW = rope_pkg::CNT_W;
    localparam int DW = rope_pkg::DATA_W;

    // configuration and count
    logic [HW-1:0]           half_dim_reg;
    logic                    layout_reg;
    logic [CW-1:0]           cnt_reg;
    logic [CW-1:0]           cnt_next;

    // memories
    logic [2*DW-1:0]         tbl_mem [2**rope_pkg::TBL_AW];
    logic [DW-1:0]           held_mem [rope_pkg::MAX_HALF_DIM];
    logic [2*DW-1:0]         tbl_rd_reg;
    logic [DW-1:0]           held_rd_reg;

    // first pipeline stage
    rope_pkg::rope_tag_t     tag1_reg;
    rope_pkg::rope_tag_t     tag1_next;
    logic signed [DW-1:0]    x1_reg;

    // math outputs
    rope_pkg::rope_tag_t     tag2;
    logic signed [DW-1:0]    y0_res;
    logic signed [DW-1:0]    y1_res;

    // output stage
    logic                    ov_reg;
    logic                    osel_reg;
    logic [DW-1:0]           oy0_reg;
    logic [DW-1:0]           oy1_reg;
    logic [CW-1:0]           oi0_reg;
    logic [CW-1:0]           oi1_reg;

    // unpacked request
    logic [rope_pkg::POS_W-1:0]  pos_id;
    logic [rope_pkg::PIDX_W-1:0] pair_index;
    logic [DW-1:0]               sin_val;
    logic [DW-1:0]               cos_val;
    logic [DW-1:0]               x_val;

    logic                    in_acc;
    logic                    is_elem;
    logic                    out_free;
    logic                    adv;
    logic [HW-1:0]           h_eff;
    logic [HW:0]             two_h;
    logic [CW-1:0]           c;
    logic [CW:0]             c_inc;
    logic                    hold;
    logic [CW-1:0]           i_full;
    logic [rope_pkg::COL_W-1:0] col;
    logic [rope_pkg::ROW_W-1:0] row;
    logic [CW-1:0]           idx0;

    assign pos_id     = s_axis_tdata[9:0];
    assign pair_index = s_axis_tdata[15:10];
    assign sin_val    = s_axis_tdata[31:16];
    assign cos_val    = s_axis_tdata[47:32];
    assign x_val      = s_axis_tdata[63:48];

    assign row     = pos_id[rope_pkg::ROW_W-1:0];
    assign is_elem = (s_axis_tuser == rope_pkg::OP_ELEM);

    // output frees up when empty or when its second result leaves now
    assign out_free      = !ov_reg || (osel_reg && m_axis_tready);
    assign adv           = !tag2.pair || out_free;
    assign s_axis_tready = adv;
    assign in_acc        = s_axis_tvalid && adv;

    always_comb
    begin
        if (half_dim_reg == '0)
        begin
            h_eff = HW'(1);
        end
        else if (half_dim_reg > HW'(rope_pkg::MAX_HALF_DIM))
        begin
            h_eff = HW'(rope_pkg::MAX_HALF_DIM);
        end
        else
        begin
            h_eff = half_dim_reg;
        end
        two_h = {h_eff, 1'b0};

        // restart if half_dim was lowered under the count
        if ((HW+1)'(cnt_reg) >= two_h)
        begin
            c = '0;
        end
        else
        begin
            c = cnt_reg;
        end
        c_inc = (CW+1)'(c) + (CW+1)'(1);
        if ((HW+1)'(c_inc) >= two_h)
        begin
            cnt_next = '0;
        end
        else
        begin
            cnt_next = c_inc[CW-1:0];
        end

        if (layout_reg == rope_pkg::LAYOUT_INTERLEAVED)
        begin
            hold   = !c[0];
            i_full = c >> 1;
            idx0   = c - CW'(1);
        end
        else
        begin
            hold   = (HW+1)'(c) < (HW+1)'(h_eff);
            i_full = hold ? c : c - CW'(h_eff);
            idx0   = i_full;
        end
        col = i_full[rope_pkg::COL_W-1:0];

        tag1_next.pair = in_acc && is_elem && !hold;
        tag1_next.idx0 = idx0;
        tag1_next.idx1 = c;
    end

    // configuration and element count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_dim_reg <= HW'(rope_pkg::MAX_HALF_DIM);
            layout_reg   <= rope_pkg::LAYOUT_SPLIT;
            cnt_reg      <= '0;
        end
        else if (cfg_we && cfg_index == rope_pkg::REG_HALF_DIM)
        begin
            half_dim_reg <= cfg_data[HW-1:0];
            cnt_reg      <= '0;
        end
        else if (cfg_we && cfg_index == rope_pkg::REG_LAYOUT)
        begin
            layout_reg <= cfg_data[0];
            cnt_reg    <= '0;
        end
        else if (in_acc && is_elem)
        begin
            cnt_reg <= cnt_next;
        end
    end

    // table memory: one write port, one read port
    always_ff @(posedge clk)
    begin
        if (in_acc && !is_elem)
        begin
            tbl_mem[{row, pair_index[rope_pkg::COL_W-1:0]}] <= {sin_val, cos_val};
        end
        if (adv)
        begin
            tbl_rd_reg <= tbl_mem[{row, col}];
        end
    end

    // held first elements; a pair's partner is always read a later cycle
    always_ff @(posedge clk)
    begin
        if (in_acc && is_elem && hold)
        begin
            held_mem[col] <= x_val;
        end
        if (adv)
        begin
            held_rd_reg <= held_mem[col];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
        end
        else if (adv)
        begin
            tag1_reg <= tag1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= x_val;
        end
    end

    rope_pair_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .tag_in  (tag1_reg),
        .x0      (held_rd_reg),
        .x1      (x1_reg),
        .sin_v   (tbl_rd_reg[2*DW-1:DW]),
        .cos_v   (tbl_rd_reg[DW-1:0]),
        .tag_out (tag2),
        .y0      (y0_res),
        .y1      (y1_res)
    );

    // output stage holds both results of a pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            osel_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ov_reg   <= tag2.pair;
            osel_reg <= 1'b0;
        end
        else if (!osel_reg && m_axis_tready)
        begin
            osel_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && tag2.pair)
        begin
            oy0_reg <= y0_res;
            oy1_reg <= y1_res;
            oi0_reg <= tag2.idx0;
            oi1_reg <= tag2.idx1;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tlast  = osel_reg;
    assign m_axis_tdata  = osel_reg
                         ? {1'b0, rope_pkg::ELEM_W'(oi1_reg), oy1_reg}
                         : {1'b0, rope_pkg::ELEM_W'(oi0_reg), oy0_reg};

endmodule
